// ===== rtl/core/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants for the integer to ASCII converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned RADIX_W   = 6;
   localparam int unsigned CHAR_W    = 7;
   localparam int unsigned DIV_STEPS = VALUE_W;
   localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
   localparam logic [RADIX_W-1:0] DIGIT_NINE  = 6'd9;
   localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] REG_RADIX = 2'd0;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one classified conversion job
   typedef struct packed {
      logic [VALUE_W-1:0] mag;
      logic               negative;
      logic [RADIX_W-1:0] base;
   } job_type;

   // back end state, one-hot
   typedef enum logic [3:0] {
      ST_LOAD = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_SIGN = 4'b0100,
      ST_EMIT = 4'b1000
   } back_state_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] d_ext;
      d_ext = {{(CHAR_W-RADIX_W){1'b0}}, d};
      if (d > DIGIT_NINE) begin
         digit_char = d_ext - {{(CHAR_W-RADIX_W){1'b0}}, DIGIT_TEN} + CHAR_A;
      end else begin
         digit_char = d_ext + CHAR_ZERO;
      end
   endfunction

endpackage

// ===== rtl/core/itoa_if.sv =====
// ----------------------------------------------------------------------------
// itoa_if
// Valid/ready channels for input values and output characters.
// ----------------------------------------------------------------------------
interface itoa_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [itoa_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface itoa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [itoa_pkg::CHAR_W-1:0]   char_code;
   logic                          last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ===== rtl/core/itoa_front.sv =====
// ----------------------------------------------------------------------------
// itoa_front
// Accepts values, clamps the radix and splits off the sign for radix ten.
// ----------------------------------------------------------------------------
module itoa_front (
   itoa_req_if.sink                      req_bus,
   input  logic [itoa_pkg::RADIX_W-1:0]  radix,
   input  logic                          queue_full,
   output logic                          push,
   output itoa_pkg::job_type             push_job
);

   logic [itoa_pkg::RADIX_W-1:0] base;
   logic [itoa_pkg::VALUE_W-1:0] bits;
   logic                         negative;

   assign req_bus.ready = !queue_full;
   assign push          = req_bus.valid && !queue_full;

   always_comb begin
      if (radix < itoa_pkg::RADIX_MIN) begin
         base = itoa_pkg::RADIX_MIN;
      end else if (radix > itoa_pkg::RADIX_MAX) begin
         base = itoa_pkg::RADIX_MAX;
      end else begin
         base = radix;
      end
   end

   assign bits     = req_bus.value;
   assign negative = (base == itoa_pkg::RADIX_DEC) && bits[itoa_pkg::VALUE_W-1];

   always_comb begin
      push_job.base     = base;
      push_job.negative = negative;
      push_job.mag      = negative ? (~bits + 1'b1) : bits;
   end

endmodule

// ===== rtl/core/itoa_queue.sv =====
// ----------------------------------------------------------------------------
// itoa_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module itoa_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  itoa_pkg::job_type  push_job,
   output logic               full,
   input  logic               pop,
   output logic               avail,
   output itoa_pkg::job_type  pop_job
);

   itoa_pkg::job_type                slot_ff [itoa_pkg::QUEUE_DEPTH];
   logic [itoa_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [itoa_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [itoa_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;
   logic                             do_push, do_pop;

   assign full    = (cnt_ff == itoa_pkg::QCNT_W'(itoa_pkg::QUEUE_DEPTH));
   assign avail   = (cnt_ff != '0);
   assign pop_job = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && avail;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/itoa_back.sv =====
// ----------------------------------------------------------------------------
// itoa_back
// Bit-serial divider producing digits LSB first into a character buffer,
// then streams the buffer out most significant first.
// ----------------------------------------------------------------------------
module itoa_back #(
   parameter int unsigned MAX_DIGITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_avail,
   input  itoa_pkg::job_type  job,
   output logic               job_pop,
   itoa_rsp_if.source         rsp_bus
);

   localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int unsigned IDX_W = $clog2(MAX_DIGITS);

   itoa_pkg::back_state_type           state_ff, state_in;
   logic [itoa_pkg::VALUE_W-1:0]       quot_ff, quot_in;
   logic [itoa_pkg::RADIX_W-1:0]       rem_ff, rem_in;
   logic [itoa_pkg::RADIX_W-1:0]       base_ff, base_in;
   logic                               neg_ff, neg_in;
   logic [itoa_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [CNT_W-1:0]                   cnt_ff, cnt_in;
   logic [itoa_pkg::CHAR_W-1:0]        char_ff [MAX_DIGITS];
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [itoa_pkg::CHAR_W-1:0]        rsp_char_ff, rsp_char_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic [itoa_pkg::RADIX_W:0]         trial;
   logic                               qbit;
   logic [itoa_pkg::RADIX_W-1:0]       rem_step;
   logic [itoa_pkg::VALUE_W-1:0]       quot_step;
   logic                               buf_we;
   logic [IDX_W-1:0]                   buf_waddr;
   logic [itoa_pkg::CHAR_W-1:0]        buf_wdata;
   logic [IDX_W-1:0]                   rd_idx;
   logic                               out_free;
   logic                               last_step;

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.char_code = rsp_char_ff;
   assign rsp_bus.last      = rsp_last_ff;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign trial     = {rem_ff, quot_ff[itoa_pkg::VALUE_W-1]};
   assign qbit      = (trial >= {1'b0, base_ff});
   assign rem_step  = qbit ? itoa_pkg::RADIX_W'(trial - {1'b0, base_ff})
                           : itoa_pkg::RADIX_W'(trial);
   assign quot_step = {quot_ff[itoa_pkg::VALUE_W-2:0], qbit};
   assign last_step = (step_ff == itoa_pkg::STEP_W'(itoa_pkg::DIV_STEPS - 1));

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign rd_idx   = IDX_W'(cnt_ff - 1'b1);

   always_comb begin
      state_in     = state_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      base_in      = base_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      job_pop      = 1'b0;
      buf_we       = 1'b0;
      buf_waddr    = IDX_W'(cnt_ff);
      buf_wdata    = itoa_pkg::digit_char(rem_step);
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         itoa_pkg::ST_LOAD: begin
            if (job_avail) begin
               job_pop  = 1'b1;
               quot_in  = job.mag;
               base_in  = job.base;
               neg_in   = job.negative;
               rem_in   = '0;
               step_in  = '0;
               cnt_in   = '0;
               state_in = itoa_pkg::ST_DIV;
            end
         end
         itoa_pkg::ST_DIV: begin
            step_in = step_ff + 1'b1;
            if (last_step) begin
               // digit done: store it, restart on the quotient
               buf_we  = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
               rem_in  = '0;
               quot_in = quot_step;
               if ((quot_step == '0) || (cnt_ff + 1'b1 == CNT_W'(MAX_DIGITS))) begin
                  state_in = neg_ff ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT;
               end
            end else begin
               rem_in  = rem_step;
               quot_in = quot_step;
            end
         end
         itoa_pkg::ST_SIGN: begin
            // drop the sign if the buffer is already full
            if (cnt_ff != CNT_W'(MAX_DIGITS)) begin
               buf_we    = 1'b1;
               buf_wdata = itoa_pkg::CHAR_MINUS;
               cnt_in    = cnt_ff + 1'b1;
            end
            state_in = itoa_pkg::ST_EMIT;
         end
         itoa_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = char_ff[rd_idx];
               rsp_last_in  = (cnt_ff == CNT_W'(1));
               cnt_in       = cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = itoa_pkg::ST_LOAD;
               end
            end
         end
         default: begin
            state_in = itoa_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itoa_pkg::ST_LOAD;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      base_ff     <= base_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (buf_we) begin
         char_ff[buf_waddr] <= buf_wdata;
      end
   end

endmodule

// ===== rtl/core/int_to_ascii_radix.sv =====
// ----------------------------------------------------------------------------
// int_to_ascii_radix
// Converts a 32-bit integer to ASCII text in a programmable radix.
// ----------------------------------------------------------------------------
//   channel   direction  beat contents
//   req_bus   in         value (32-bit signed)
//   rsp_bus   out        char_code (7-bit ASCII), last
//   csr_*     in/out     APB register: radix at byte address 0
//
// Each digit costs a full pass of the bit-serial divider: the back end loads
// a job, divides out its digits, writes a sign when the value is negative in
// radix ten, then streams the characters out, most significant first.
// A two-entry queue lets the front accept values while the back converts.
// Reset clears control state and sets radix to 10.
// A stalled rsp_bus holds the character; the divider keeps nothing in flight.
// ----------------------------------------------------------------------------
module int_to_ascii_radix #(
   parameter int unsigned MAX_DIGITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   itoa_req_if.sink                           req_bus,
   itoa_rsp_if.source                         rsp_bus,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [itoa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [itoa_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [itoa_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   logic [itoa_pkg::RADIX_W-1:0] radix_ff, radix_in;
   logic                         push, queue_full, job_avail, job_pop;
   itoa_pkg::job_type            push_job, pop_job;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == itoa_pkg::REG_RADIX)
                       ? {{(itoa_pkg::CSR_DATA_W-itoa_pkg::RADIX_W){1'b0}}, radix_ff}
                       : '0;

   always_comb begin
      radix_in = radix_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == itoa_pkg::REG_RADIX)) begin
         radix_in = csr_pwdata[itoa_pkg::RADIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= itoa_pkg::RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   itoa_front u_front (
      .req_bus    (req_bus),
      .radix      (radix_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   itoa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (job_pop),
      .avail    (job_avail),
      .pop_job  (pop_job)
   );

   itoa_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_avail (job_avail),
      .job       (pop_job),
      .job_pop   (job_pop),
      .rsp_bus   (rsp_bus)
   );

endmodule
